[hw/rtl/text_screen_buffer_macros.svh]
// Assertion macros for the text screen buffer RTL.
`ifndef TEXT_SCREEN_BUFFER_MACROS_SVH
`define TEXT_SCREEN_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TSB_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tsb_pkg.sv]
// Shared constants, operation codes and command type of the text screen buffer.
`default_nettype none

package tsb_pkg;

  localparam int COLUMNS = 16;
  localparam int ROWS    = 8;
  localparam int NCELLS  = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(NCELLS);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] BLANK        = 8'd32;
  localparam logic [6:0] CURSOR_GLYPH = 7'd127;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_PUT     = 3'd1,
    OP_NEWLINE = 3'd2,
    OP_MOVE    = 3'd3,
    OP_READ    = 3'd4,
    OP_CLEAN   = 3'd5,
    OP_NOP     = 3'd6
  } op_e;

  // Classified command: column and row are already clamped into the screen.
  typedef struct packed {
    op_e              op;
    logic [7:0]       ch;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             col_ok;
    logic             row_ok;
    logic             imode;
    logic             flash;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/tsb_front.sv]
// Input side: accepts transfers and classifies them into screen commands.
`default_nettype none

module tsb_front import tsb_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        func_i,
  input  logic [7:0]        char_code_i,
  input  logic signed [7:0] col_i,
  input  logic signed [7:0] row_i,
  input  logic              input_mode_i,
  input  logic              flash_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  localparam logic signed [7:0] COL_MAX = 8'(COLUMNS - 1);
  localparam logic signed [7:0] ROW_MAX = 8'(ROWS - 1);

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o       = '0;
    cmd_o.ch    = char_code_i;
    cmd_o.imode = input_mode_i;
    cmd_o.flash = flash_i;

    // Map unused function codes to no operation
    unique case (func_i) inside
      OP_CLEAR, OP_PUT, OP_NEWLINE, OP_MOVE, OP_READ, OP_CLEAN: cmd_o.op = op_e'(func_i);
      default: cmd_o.op = OP_NOP;
    endcase

    // Range-check and clamp column
    cmd_o.col_ok = !col_i[7] && (col_i <= COL_MAX);
    if (col_i[7]) begin
      cmd_o.col = '0;
    end else if (col_i > COL_MAX) begin
      cmd_o.col = COL_MAX[COL_W-1:0];
    end else begin
      cmd_o.col = col_i[COL_W-1:0];
    end

    // Range-check and clamp row
    cmd_o.row_ok = !row_i[7] && (row_i <= ROW_MAX);
    if (row_i[7]) begin
      cmd_o.row = '0;
    end else if (row_i > ROW_MAX) begin
      cmd_o.row = ROW_MAX[ROW_W-1:0];
    end else begin
      cmd_o.row = row_i[ROW_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tsb_queue.sv]
// Short command queue between the front and back of the screen buffer.
`default_nettype none

module tsb_queue import tsb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o
);

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

  cmd_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o    = (count_q == CNT_FULL);
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = entry_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tsb_back.sv]
// Execution side: cell memory, cursor, dirty marks and the result register.
`default_nettype none

`include "text_screen_buffer_macros.svh"

module tsb_back import tsb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] glyph_o,
  output logic       row_redraw_o,
  output logic [5:0] cursor_col_o,
  output logic [4:0] cursor_row_o
);

  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_LAST   = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_END     = ADDR_W'(COLUMNS - 1);
  localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_READ,
    ST_RESP
  } state_e;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [ROWS-1:0]   dirty_q, dirty_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] fill_addr_q, fill_addr_d;
  logic [ADDR_W-1:0] fill_end_q, fill_end_d;
  logic [6:0]        res_glyph_q, res_glyph_d;
  logic              res_redraw_q, res_redraw_d;
  logic              out_valid_q, out_valid_d;
  logic [6:0]        out_glyph_q, out_glyph_d;
  logic              out_redraw_q, out_redraw_d;
  logic [5:0]        out_col_q, out_col_d;
  logic [4:0]        out_row_q, out_row_d;

  logic [7:0]        mem_q [NCELLS];
  logic [7:0]        rd_data_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  logic [ROW_W-1:0]  row_next;
  logic [ADDR_W-1:0] cur_addr, cmd_addr, next_row_addr;

  assign row_next      = cur_row_q + ROW_W'(1);
  assign cur_addr      = ADDR_W'(ADDR_W'(cur_row_q) * ROW_SPAN) + ADDR_W'(cur_col_q);
  assign cmd_addr      = ADDR_W'(ADDR_W'(q_cmd_i.row) * ROW_SPAN) + ADDR_W'(q_cmd_i.col);
  assign next_row_addr = ADDR_W'(ADDR_W'(row_next) * ROW_SPAN);

  assign out_valid_o  = out_valid_q;
  assign glyph_o      = out_glyph_q;
  assign row_redraw_o = out_redraw_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;

  // Cell memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  // Sequence one command at a time
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    dirty_d      = dirty_q;
    cnt_d        = cnt_q;
    fill_addr_d  = fill_addr_q;
    fill_end_d   = fill_end_q;
    res_glyph_d  = res_glyph_q;
    res_redraw_d = res_redraw_q;
    out_valid_d  = out_valid_q;
    out_glyph_d  = out_glyph_q;
    out_redraw_d = out_redraw_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = fill_addr_q;
    mem_wdata    = BLANK;
    mem_raddr    = cnt_q + ROW_SPAN;

    // Drop the result once the receiver takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o      = 1'b1;
          cmd_d        = q_cmd_i;
          res_glyph_d  = '0;
          res_redraw_d = 1'b0;
          state_d      = ST_RESP;
          unique case (q_cmd_i.op)
            OP_CLEAR: begin
              cur_col_d   = '0;
              cur_row_d   = '0;
              dirty_d     = '1;
              fill_addr_d = '0;
              fill_end_d  = LAST_ADDR;
              state_d     = ST_FILL;
            end
            OP_PUT: begin
              mem_we              = 1'b1;
              mem_waddr           = cur_addr;
              mem_wdata           = q_cmd_i.ch;
              dirty_d[cur_row_q]  = 1'b1;
              if (cur_col_q == COL_LAST) begin
                cur_col_d = '0;
                if (cur_row_q == ROW_LAST) begin
                  dirty_d = '1;
                  cnt_d   = '0;
                  state_d = ST_SCR_RD;
                end else begin
                  cur_row_d = row_next;
                end
              end else begin
                cur_col_d = cur_col_q + COL_W'(1);
              end
            end
            OP_NEWLINE: begin
              cur_col_d = '0;
              if (cur_row_q == ROW_LAST) begin
                dirty_d = '1;
                cnt_d   = '0;
                state_d = ST_SCR_RD;
              end else begin
                cur_row_d         = row_next;
                dirty_d[row_next] = 1'b1;
                fill_addr_d       = next_row_addr;
                fill_end_d        = next_row_addr + ROW_END;
                state_d           = ST_FILL;
              end
            end
            OP_MOVE: begin
              cur_col_d = q_cmd_i.col;
              cur_row_d = q_cmd_i.row;
            end
            OP_READ: begin
              if (q_cmd_i.col_ok && q_cmd_i.row_ok) begin
                mem_raddr = cmd_addr;
                state_d   = ST_READ;
              end else begin
                res_glyph_d = BLANK[6:0];
              end
            end
            OP_CLEAN: begin
              if (q_cmd_i.row_ok) begin
                dirty_d[q_cmd_i.row] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCR_RD: begin
        state_d = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        // Copy one cell up a row, then blank the bottom row
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = rd_data_q;
        if (cnt_q == COPY_LAST) begin
          fill_addr_d = BOTTOM_ADDR;
          fill_end_d  = LAST_ADDR;
          state_d     = ST_FILL;
        end else begin
          cnt_d   = cnt_q + ADDR_W'(1);
          state_d = ST_SCR_RD;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (fill_addr_q == fill_end_q) begin
          state_d = ST_RESP;
        end else begin
          fill_addr_d = fill_addr_q + ADDR_W'(1);
        end
      end
      ST_READ: begin
        // Substitute non-printing bytes and overlay the cursor glyph
        if (!rd_data_q[7] && (rd_data_q[6:5] != 2'b00)) begin
          res_glyph_d = rd_data_q[6:0];
        end else begin
          res_glyph_d = BLANK[6:0];
        end
        if (cmd_q.col == cur_col_q && cmd_q.row == cur_row_q && cmd_q.imode && cmd_q.flash) begin
          res_glyph_d = CURSOR_GLYPH;
        end
        res_redraw_d = dirty_q[cmd_q.row] || (cmd_q.imode && cmd_q.row == cur_row_q);
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        // Hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_glyph_d  = res_glyph_q;
          out_redraw_d = res_redraw_q;
          out_col_d    = 6'(cur_col_q);
          out_row_d    = 5'(cur_row_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      dirty_q      <= '0;
      out_valid_q  <= 1'b0;
      cmd_q        <= '0;
      cnt_q        <= '0;
      fill_addr_q  <= '0;
      fill_end_q   <= '0;
      res_glyph_q  <= '0;
      res_redraw_q <= 1'b0;
      out_glyph_q  <= '0;
      out_redraw_q <= 1'b0;
      out_col_q    <= '0;
      out_row_q    <= '0;
    end else begin
      state_q      <= state_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      dirty_q      <= dirty_d;
      out_valid_q  <= out_valid_d;
      cmd_q        <= cmd_d;
      cnt_q        <= cnt_d;
      fill_addr_q  <= fill_addr_d;
      fill_end_q   <= fill_end_d;
      res_glyph_q  <= res_glyph_d;
      res_redraw_q <= res_redraw_d;
      out_glyph_q  <= out_glyph_d;
      out_redraw_q <= out_redraw_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
    end
  end

  `TSB_ASSERT(cur_col_range_a, 1'b1, cur_col_q <= COL_LAST, "cursor column left the screen")
  `TSB_ASSERT(cur_row_range_a, 1'b1, cur_row_q <= ROW_LAST, "cursor row left the screen")
  `TSB_ASSERT(fill_bounds_a, state_q == ST_FILL, fill_addr_q <= fill_end_q, "fill ran past its end")
  `TSB_ASSERT_NEXT(clear_home_a, q_pop_o && q_cmd_i.op == OP_CLEAR, state_q == ST_FILL && cur_col_q == '0 && cur_row_q == '0 && (&dirty_q), "clear did not home and mark all rows")

endmodule

`default_nettype wire

[hw/rtl/text_screen_buffer.sv]
// Top level of the character-cell text screen buffer.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries an operation
// per transfer: clear, put char, newline, move cursor, read cell, clean row.
// One output channel (out_valid_o / out_stall_i) returns exactly one result
// per operation, in order: glyph and redraw flag for a read, and the cursor
// position after the operation.
// A read adds a registered cell read before its result; a newline without
// scroll also blanks its row; clear fills every cell; a scroll copies the
// (ROWS-1)*COLUMNS upper cells up a row (read then write, one port) and
// then blanks the bottom row. The command sequencer walks one command at a
// time and takes the next once the last result sits in the result register.
// A two-entry command queue keeps accepting while the sequencer works, and a
// result register keeps the sequencer going while the receiver is idle.
// Reset clears cursor, dirty marks, queue and result; the cell memory is not
// cleared, so issue a clear before reading cells. When the receiver stalls,
// the result holds, the sequencer waits, and the input stalls once the queue
// is full.
`default_nettype none

module text_screen_buffer import tsb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        func_i,
  input  logic [7:0]        char_code_i,
  input  logic signed [7:0] col_i,
  input  logic signed [7:0] row_i,
  input  logic              input_mode_i,
  input  logic              flash_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        glyph_o,
  output logic              row_redraw_o,
  output logic [5:0]        cursor_col_o,
  output logic [4:0]        cursor_row_o
);

  cmd_t push_cmd, pop_cmd;
  logic push, q_full, q_valid, q_pop;

  // Classify incoming transfers
  tsb_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .input_mode_i (input_mode_i),
    .flash_i      (flash_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Buffer commands between front and back
  tsb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .pop_cmd_o  (pop_cmd)
  );

  // Execute commands and return results
  tsb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (pop_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .glyph_o      (glyph_o),
    .row_redraw_o (row_redraw_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o)
  );

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the text screen buffer: directed and random operations.
module tb;
  import tsb_pkg::*;

  // Spare operation code with no named member in the package
  localparam logic [2:0] OP_SPARE = 3'd7;
  localparam int IDLE_PCT    = 23;
  localparam int RAND_OPS    = 550;
  localparam int MAX_REPORTS = 10;
  // Allow much longer than a scroll with one op queued behind it before
  // declaring a hang.
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [2:0]        func;
    logic [7:0]        ch;
    logic signed [7:0] col;
    logic signed [7:0] row;
    logic              imode;
    logic              flash;
  } screen_op_t;

  typedef struct packed {
    logic [6:0] glyph;
    logic       redraw;
    logic [5:0] ccol;
    logic [4:0] crow;
  } screen_view_t;

  // Track screen contents and cursor, hold the views each operation should return
  class screen_tracker;
    logic [7:0]   cells [NCELLS];
    bit           dirty [ROWS];
    int           ccol;
    int           crow;
    screen_view_t pending_views [$];
    int           mismatches;
    int           compared;
    int           scrolls;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (dirty[r]) dirty[r] = 1'b0;
      ccol = 0;
      crow = 0;
      mismatches = 0;
      compared = 0;
      scrolls = 0;
    endfunction

    // Move rows up, blank the bottom row, mark all rows dirty
    function void shift_up();
      for (int i = 0; i < NCELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      for (int i = NCELLS - COLUMNS; i < NCELLS; i++) cells[i] = BLANK;
      foreach (dirty[r]) dirty[r] = 1'b1;
      scrolls++;
    endfunction

    function void note_op(screen_op_t op);
      screen_view_t v;
      int pos;
      int c;
      int r;
      logic [7:0] stored;
      v = '0;
      c = int'($signed(op.col));
      r = int'($signed(op.row));
      case (op.func)
        OP_CLEAR: begin
          foreach (cells[i]) cells[i] = BLANK;
          foreach (dirty[i]) dirty[i] = 1'b1;
          ccol = 0;
          crow = 0;
        end
        OP_PUT: begin
          pos = crow * COLUMNS + ccol;
          dirty[pos / COLUMNS] = 1'b1;
          cells[pos] = op.ch;
          pos++;
          if (pos >= NCELLS) begin
            shift_up();
            pos -= COLUMNS;
          end
          ccol = pos % COLUMNS;
          crow = pos / COLUMNS;
        end
        OP_NEWLINE: begin
          ccol = 0;
          crow++;
          if (crow >= ROWS) begin
            shift_up();
            crow = ROWS - 1;
          end
          for (int i = 0; i < COLUMNS; i++) cells[crow * COLUMNS + i] = BLANK;
          dirty[crow] = 1'b1;
        end
        OP_MOVE: begin
          ccol = (c < 0) ? 0 : (c > COLUMNS - 1) ? COLUMNS - 1 : c;
          crow = (r < 0) ? 0 : (r > ROWS - 1) ? ROWS - 1 : r;
        end
        OP_READ: begin
          if (c >= 0 && c < COLUMNS && r >= 0 && r < ROWS) begin
            stored = cells[r * COLUMNS + c];
            // bytes with the top bit set show as blanks
            v.glyph = (stored >= BLANK && !stored[7]) ? stored[6:0] : BLANK[6:0];
            if (c == ccol && r == crow && op.imode && op.flash) v.glyph = CURSOR_GLYPH;
            v.redraw = dirty[r] || (op.imode && r == crow);
          end else begin
            v.glyph = BLANK[6:0];
          end
        end
        OP_CLEAN: begin
          if (r >= 0 && r < ROWS) dirty[r] = 1'b0;
        end
        default: begin
        end
      endcase
      v.ccol = ccol[5:0];
      v.crow = crow[4:0];
      pending_views.push_back(v);
    endfunction

    function void check_result(screen_view_t got);
      screen_view_t want;
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: unexpected result glyph %0d redraw %0d cursor %0d,%0d",
                   got.glyph, got.redraw, got.ccol, got.crow);
        return;
      end
      want = pending_views.pop_front();
      compared++;
      if (got.glyph !== want.glyph || got.redraw !== want.redraw ||
          got.ccol !== want.ccol || got.crow !== want.crow) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $write("tb: result %0d expected glyph %0d redraw %0d cursor %0d,%0d,",
                 compared, want.glyph, want.redraw, want.ccol, want.crow);
          $display(" got glyph %0d redraw %0d cursor %0d,%0d",
                   got.glyph, got.redraw, got.ccol, got.crow);
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [2:0]        func_i = OP_NOP;
  logic [7:0]        char_code_i = '0;
  logic signed [7:0] col_i = '0;
  logic signed [7:0] row_i = '0;
  logic              input_mode_i = 1'b0;
  logic              flash_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [6:0]        glyph_o;
  logic              row_redraw_o;
  logic [5:0]        cursor_col_o;
  logic [4:0]        cursor_row_o;

  bit            calm = 1'b0;
  int            quiet_cycles = 0;
  int            op_count [8];
  screen_tracker sb = new();

  text_screen_buffer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .input_mode_i (input_mode_i),
    .flash_i      (flash_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .glyph_o      (glyph_o),
    .row_redraw_o (row_redraw_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stall the result side at random, except in the calm window
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Check every result transfer against the oldest pending view
  always @(posedge clk_i) begin
    screen_view_t got;
    got = '{glyph: glyph_o, redraw: row_redraw_o, ccol: cursor_col_o, crow: cursor_row_o};
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(got);
  end

  // Count cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("tb: no transfer for %0d cycles", QUIET_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  // Offer one operation, with random idle cycles first; return once transferred
  task automatic send_op(screen_op_t op);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= op.func;
    char_code_i  <= op.ch;
    col_i        <= op.col;
    row_i        <= op.row;
    input_mode_i <= op.imode;
    flash_i      <= op.flash;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_op(op);
    op_count[op.func]++;
  endtask

  // Hold off the sender until every pending view has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_views.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    screen_op_t op;
    int k;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clear first so every later read hits written cells
    send_op('{OP_CLEAR,   8'h00, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_READ,    8'h00, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_CLEAN,   8'h00, 8'sd0,    8'sd0,    1'b0, 1'b0});
    // cursor glyph and forced redraw on a clean cursor row
    send_op('{OP_READ,    8'h00, 8'sd0,    8'sd0,    1'b1, 1'b1});
    send_op('{OP_PUT,     8'h41, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_PUT,     8'h00, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_PUT,     8'h1F, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_PUT,     8'h7F, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_PUT,     8'h80, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_PUT,     8'hFF, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_READ,    8'h00, 8'sd5,    8'sd0,    1'b1, 1'b0});
    send_op('{OP_READ,    8'h00, 8'sd3,    8'sd0,    1'b0, 1'b1});
    send_op('{OP_MOVE,    8'h00, -8'sd128, -8'sd128, 1'b0, 1'b0});
    send_op('{OP_MOVE,    8'h00, 8'sd127,  8'sd127,  1'b0, 1'b0});
    // put in the last cell scrolls the screen
    send_op('{OP_PUT,     8'h7E, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_READ,    8'h00, 8'sd15,   8'sd6,    1'b0, 1'b0});
    // newline on the bottom row scrolls too
    send_op('{OP_NEWLINE, 8'h00, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_MOVE,    8'h00, 8'sd3,    8'sd2,    1'b0, 1'b0});
    send_op('{OP_NEWLINE, 8'h00, 8'sd0,    8'sd0,    1'b0, 1'b0});
    send_op('{OP_READ,    8'h00, -8'sd1,   8'sd0,    1'b0, 1'b0});
    send_op('{OP_READ,    8'h00, 8'sd16,   8'sd8,    1'b1, 1'b1});
    send_op('{OP_CLEAN,   8'h00, 8'sd0,    -8'sd1,   1'b0, 1'b0});
    send_op('{OP_CLEAN,   8'h00, 8'sd0,    8'sd8,    1'b0, 1'b0});
    send_op('{OP_CLEAN,   8'h00, 8'sd0,    8'sd7,    1'b0, 1'b0});
    send_op('{OP_NOP,     8'hFF, 8'sd0,    8'sd0,    1'b1, 1'b1});
    send_op('{OP_SPARE,   8'hFF, 8'sd0,    8'sd0,    1'b1, 1'b1});
    send_op('{OP_READ,    8'h00, 8'sd0,    8'sd7,    1'b1, 1'b0});
    drain();

    // Random: mostly text output with reads and cursor moves in range
    for (int n = 0; n < RAND_OPS; n++) begin
      if (n == 150 || n == 400) drain();
      if (n == 200) calm <= 1'b1;
      if (n == 300) calm <= 1'b0;
      k = $urandom_range(99);
      op.func = (k < 40) ? OP_PUT : (k < 52) ? OP_NEWLINE : (k < 62) ? OP_MOVE :
                (k < 85) ? OP_READ : (k < 93) ? OP_CLEAN : (k < 95) ? OP_CLEAR :
                (k < 97) ? OP_NOP : OP_SPARE;
      op.ch    = ($urandom_range(99) < 75) ? 8'($urandom_range(126, 32)) : 8'($urandom);
      op.col   = ($urandom_range(99) < 80) ? 8'($urandom_range(COLUMNS - 1)) : 8'($urandom);
      op.row   = ($urandom_range(99) < 80) ? 8'($urandom_range(ROWS - 1)) : 8'($urandom);
      op.imode = 1'($urandom);
      op.flash = 1'($urandom);
      send_op(op);
    end
    in_valid_i <= 1'b0;

    while (sb.pending_views.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("tb: sent %0d puts, %0d newlines, %0d reads, %0d moves, %0d clears",
             op_count[OP_PUT], op_count[OP_NEWLINE], op_count[OP_READ],
             op_count[OP_MOVE], op_count[OP_CLEAR]);
    $display("tb: %0d results compared, %0d scrolls predicted, %0d mismatches",
             sb.compared, sb.scrolls, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_views.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
